// ----- design/gace_pkg.sv -----
// shared types, constants and helpers for the adjacency closure engine
`timescale 1ns / 1ps
package gace_pkg;

  // sizes fixed by the payload fields
  localparam int MaxVertices = 16;
  localparam int VtxW        = 4;
  localparam int RowW        = 16;
  localparam int CntW        = 5;
  localparam int EdgeW       = 7;

  typedef logic [VtxW-1:0]  vtx_t;
  typedef logic [RowW-1:0]  row_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [EdgeW-1:0] edge_cnt_t;

  localparam cnt_t      VcountMin = CntW'(1);
  localparam cnt_t      VcountMax = CntW'(MaxVertices);
  localparam edge_cnt_t MaxEdges  = EdgeW'(MaxVertices * (MaxVertices - 1) / 2);

  // request kinds
  localparam logic [1:0] KindAdd     = 2'd0;
  localparam logic [1:0] KindRemove  = 2'd1;
  localparam logic [1:0] KindQuery   = 2'd2;
  localparam logic [1:0] KindClosure = 2'd3;

  // result status codes
  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatSelfLoop = 2'd1;
  localparam logic [1:0] StatRange    = 2'd2;
  localparam logic [1:0] StatAbsent   = 2'd3;

  // one port pair of a row memory: one write and one read per cycle
  typedef struct packed {
    logic we;
    vtx_t waddr;
    row_t wdata;
    vtx_t raddr;
  } ram_req_t;

  // vertex count and its clear pulse
  typedef struct packed {
    logic clear;
    cnt_t vcount;
  } cfg_t;

  // single bit at a vertex position
  function automatic row_t vtx_bit(vtx_t v);
    row_t r;
    r    = '0;
    r[v] = 1'b1;
    return r;
  endfunction

  // ones below the vertex count
  function automatic row_t low_mask(cnt_t n);
    row_t r;
    for (int j = 0; j < RowW; j++) begin
      r[j] = (j < int'(n));
    end
    return r;
  endfunction

endpackage

// ----- design/gace_ram.sv -----
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module gace_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/gace_seq.sv -----
// request sequencer: edge updates, warshall passes and result emission over two row rams
`timescale 1ns / 1ps
module gace_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [1:0]                kind_i,
  input  gace_pkg::vtx_t            source_vertex_i,
  input  gace_pkg::vtx_t            dest_vertex_i,
  input  gace_pkg::cfg_t            cfg_i,
  input  gace_pkg::row_t            adj_rdata_i,
  input  gace_pkg::row_t            clo_rdata_i,
  output gace_pkg::ram_req_t        adj_req_o,
  output gace_pkg::ram_req_t        clo_req_o,
  output logic                      busy_o,
  output logic                      result_valid_o,
  output logic [1:0]                status_o,
  output logic                      edge_present_o,
  output gace_pkg::vtx_t            row_index_o,
  output gace_pkg::row_t            reach_row_o,
  output gace_pkg::edge_cnt_t       edge_total_o,
  output logic                      last_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EDGE_RD = 3'd1;
  localparam logic [2:0] S_EDGE_WR = 3'd2;
  localparam logic [2:0] S_INIT    = 3'd3;
  localparam logic [2:0] S_PASS    = 3'd4;
  localparam logic [2:0] S_EMIT    = 3'd5;

  logic [2:0]                     state_q, state_d;
  gace_pkg::cnt_t                 cnt_q, cnt_d;
  gace_pkg::vtx_t                 k_q, k_d;
  logic                           wpend_q, wpend_d;
  gace_pkg::vtx_t                 widx_q, widx_d;
  gace_pkg::row_t                 pivot_q, pivot_d;
  gace_pkg::row_t                 pnxt_q, pnxt_d;
  gace_pkg::edge_cnt_t            edge_cnt_q, edge_cnt_d;
  gace_pkg::row_t                 row_valid_q, row_valid_d;
  logic                           adj_ok_q, adj_ok_d;
  logic [1:0]                     kind_q, kind_d;
  gace_pkg::vtx_t                 src_q, src_d;
  gace_pkg::vtx_t                 dst_q, dst_d;
  logic                           res_valid_q, res_valid_d;
  logic [1:0]                     status_q, status_d;
  logic                           present_q, present_d;
  gace_pkg::vtx_t                 rowidx_q, rowidx_d;
  gace_pkg::row_t                 reach_q, reach_d;
  logic                           last_q, last_d;

  gace_pkg::ram_req_t             adj_req, clo_req;
  gace_pkg::row_t                 adj_row, vmask, upd_row;
  logic                           rd_issue, in_range, edge_bit, clo_rd;
  gace_pkg::cnt_t                 n_last;

  // shared decode
  assign adj_row  = adj_rdata_i & {gace_pkg::RowW{adj_ok_q}};
  assign vmask    = gace_pkg::low_mask(cfg_i.vcount);
  assign rd_issue = cnt_q < cfg_i.vcount;
  assign n_last   = cfg_i.vcount - gace_pkg::CntW'(1);
  assign in_range = ({1'b0, src_q} < cfg_i.vcount) && ({1'b0, dst_q} < cfg_i.vcount);
  assign edge_bit = adj_row[dst_q];
  assign upd_row  = clo_rdata_i[k_q] ? (clo_rdata_i | pivot_q) : clo_rdata_i;
  assign clo_rd   = rd_issue && ((state_q == S_PASS) || (state_q == S_EMIT));

  // next state and memory requests
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    wpend_d     = 1'b0;
    widx_d      = widx_q;
    pivot_d     = pivot_q;
    pnxt_d      = pnxt_q;
    edge_cnt_d  = edge_cnt_q;
    row_valid_d = row_valid_q;
    kind_d      = kind_q;
    src_d       = src_q;
    dst_d       = dst_q;
    res_valid_d = 1'b0;
    status_d    = gace_pkg::StatOk;
    present_d   = 1'b0;
    rowidx_d    = '0;
    reach_d     = '0;
    last_d      = 1'b0;
    adj_req     = '0;
    clo_req     = '0;

    unique case (state_q)
      S_IDLE: begin
        adj_req.raddr = source_vertex_i;
        if (start_i) begin
          kind_d = kind_i;
          src_d  = source_vertex_i;
          dst_d  = dest_vertex_i;
          cnt_d  = '0;
          if (kind_i == gace_pkg::KindClosure) begin
            state_d = S_INIT;
          end else begin
            state_d = S_EDGE_RD;
          end
        end
      end

      // row of the source is back: decide, write it, fetch the dest row
      S_EDGE_RD: begin
        adj_req.raddr = dst_q;
        state_d       = S_IDLE;
        unique case (kind_q)
          gace_pkg::KindQuery: begin
            res_valid_d = 1'b1;
            last_d      = 1'b1;
            status_d    = in_range ? gace_pkg::StatOk : gace_pkg::StatRange;
            present_d   = in_range & edge_bit;
          end
          gace_pkg::KindAdd: begin
            priority if (src_q == dst_q) begin
              res_valid_d = 1'b1;
              last_d      = 1'b1;
              status_d    = gace_pkg::StatSelfLoop;
            end else if (!in_range) begin
              res_valid_d = 1'b1;
              last_d      = 1'b1;
              status_d    = gace_pkg::StatRange;
            end else begin
              adj_req.we         = 1'b1;
              adj_req.waddr      = src_q;
              adj_req.wdata      = adj_row | gace_pkg::vtx_bit(dst_q);
              row_valid_d[src_q] = 1'b1;
              if (!edge_bit) begin
                edge_cnt_d = edge_cnt_q + gace_pkg::EdgeW'(1);
              end
              state_d = S_EDGE_WR;
            end
          end
          gace_pkg::KindRemove: begin
            priority if (!in_range) begin
              res_valid_d = 1'b1;
              last_d      = 1'b1;
              status_d    = gace_pkg::StatRange;
            end else if (!edge_bit) begin
              res_valid_d = 1'b1;
              last_d      = 1'b1;
              status_d    = gace_pkg::StatAbsent;
            end else begin
              adj_req.we         = 1'b1;
              adj_req.waddr      = src_q;
              adj_req.wdata      = adj_row & ~gace_pkg::vtx_bit(dst_q);
              row_valid_d[src_q] = 1'b1;
              edge_cnt_d         = edge_cnt_q - gace_pkg::EdgeW'(1);
              state_d            = S_EDGE_WR;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      // symmetric bit in the dest row
      S_EDGE_WR: begin
        adj_req.we    = 1'b1;
        adj_req.waddr = dst_q;
        if (kind_q == gace_pkg::KindAdd) begin
          adj_req.wdata = adj_row | gace_pkg::vtx_bit(src_q);
        end else begin
          adj_req.wdata = adj_row & ~gace_pkg::vtx_bit(src_q);
        end
        row_valid_d[dst_q] = 1'b1;
        res_valid_d        = 1'b1;
        last_d             = 1'b1;
        state_d            = S_IDLE;
      end

      // copy adjacency rows with the diagonal into the closure ram
      S_INIT: begin
        adj_req.raddr = cnt_q[gace_pkg::VtxW-1:0];
        if (rd_issue) begin
          cnt_d   = cnt_q + gace_pkg::CntW'(1);
          wpend_d = 1'b1;
          widx_d  = cnt_q[gace_pkg::VtxW-1:0];
        end
        if (wpend_q) begin
          clo_req.we    = 1'b1;
          clo_req.waddr = widx_q;
          clo_req.wdata = (adj_row | gace_pkg::vtx_bit(widx_q)) & vmask;
          if (widx_q == '0) begin
            pivot_d = clo_req.wdata;
          end
        end
        if (!rd_issue) begin
          cnt_d   = '0;
          k_d     = '0;
          state_d = S_PASS;
        end
      end

      // one warshall pass per pivot, next pivot row caught as it is written
      S_PASS: begin
        clo_req.raddr = cnt_q[gace_pkg::VtxW-1:0];
        if (rd_issue) begin
          cnt_d   = cnt_q + gace_pkg::CntW'(1);
          wpend_d = 1'b1;
          widx_d  = cnt_q[gace_pkg::VtxW-1:0];
        end
        if (wpend_q) begin
          clo_req.we    = 1'b1;
          clo_req.waddr = widx_q;
          clo_req.wdata = upd_row;
          if ({1'b0, widx_q} == ({1'b0, k_q} + gace_pkg::CntW'(1))) begin
            pnxt_d = upd_row;
          end
        end
        if (!rd_issue) begin
          cnt_d = '0;
          if ({1'b0, k_q} == n_last) begin
            state_d = S_EMIT;
          end else begin
            k_d     = k_q + gace_pkg::VtxW'(1);
            pivot_d = pnxt_d;
          end
        end
      end

      // stream the reachability rows out
      S_EMIT: begin
        clo_req.raddr = cnt_q[gace_pkg::VtxW-1:0];
        if (rd_issue) begin
          cnt_d   = cnt_q + gace_pkg::CntW'(1);
          wpend_d = 1'b1;
          widx_d  = cnt_q[gace_pkg::VtxW-1:0];
        end
        if (wpend_q) begin
          res_valid_d = 1'b1;
          rowidx_d    = widx_q;
          reach_d     = clo_rdata_i;
          last_d      = ({1'b0, widx_q} == n_last);
        end
        if (!rd_issue) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // vertex count write empties the adjacency store
    if (cfg_i.clear) begin
      row_valid_d = '0;
      edge_cnt_d  = '0;
    end
  end

  assign adj_ok_d = row_valid_q[adj_req.raddr];

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      wpend_q     <= 1'b0;
      edge_cnt_q  <= '0;
      row_valid_q <= '0;
      adj_ok_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      wpend_q     <= wpend_d;
      edge_cnt_q  <= edge_cnt_d;
      row_valid_q <= row_valid_d;
      adj_ok_q    <= adj_ok_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    widx_q    <= widx_d;
    pivot_q   <= pivot_d;
    pnxt_q    <= pnxt_d;
    kind_q    <= kind_d;
    src_q     <= src_d;
    dst_q     <= dst_d;
    status_q  <= status_d;
    present_q <= present_d;
    rowidx_q  <= rowidx_d;
    reach_q   <= reach_d;
    last_q    <= last_d;
  end

  assign adj_req_o      = adj_req;
  assign clo_req_o      = clo_req;
  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign edge_present_o = present_q;
  assign row_index_o    = rowidx_q;
  assign reach_row_o    = reach_q;
  assign edge_total_o   = edge_cnt_q;
  assign last_o         = last_q;

`ifndef SYNTHESIS
  // every return to idle delivers the final result of the request
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_IDLE) && ($past(state_q) != S_IDLE)) |-> (res_valid_q && last_q))
    else $error("returned to idle without a final result");

  // the edge count stays within a simple graph
  a_edge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_cnt_q <= gace_pkg::MaxEdges)
    else $error("edge count above the maximum");

  // the closure ram is never read and written at one row in a cycle
  a_clo_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clo_req.we && clo_rd) |-> (clo_req.waddr != clo_req.raddr))
    else $error("closure ram read and write collide");

  // adjacency writes only during edge updates
  a_adj_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adj_req.we |-> ((state_q == S_EDGE_RD) || (state_q == S_EDGE_WR)))
    else $error("adjacency write outside an edge update");

  // closure rows come out back to back up to the marked one
  a_rows_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !last_q) |=> res_valid_q)
    else $error("gap in the closure row stream");
`endif

endmodule

// ----- design/graph_adjacency_closure_engine.sv -----
// top level of the adjacency closure engine: vertex count register and row memories
//
//   channel   | signals                                         | handshake
//   ----------+-------------------------------------------------+--------------------------
//   request   | kind_i, source_vertex_i, dest_vertex_i          | start_i while busy_o low
//   result    | status_o, edge_present_o, row_index_o,          | result_valid_o, one cycle
//             | reach_row_o, edge_total_o, last_o               |
//   config    | cfg_wdata_i (vertex count)                      | cfg_we_i, one cycle
//
// query and rejected requests: busy while the source row is checked, result the cycle after it
// accepted add or remove: busy while the source row, then the dest row, is read and rewritten
// closure over n vertices: busy through the fill, n pivot passes and row readout, paced by
//   the one read and one write per cycle of the closure ram; the n rows come out back to
//   back with no gap
// reset gives 16 vertices and an empty graph, no clearing pass is needed
// results cannot be held off; a vertex count write clears all edges at once
`timescale 1ns / 1ps
module graph_adjacency_closure_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           kind_i,
  input  logic [3:0]           source_vertex_i,
  input  logic [3:0]           dest_vertex_i,
  input  logic                 cfg_we_i,
  input  logic [4:0]           cfg_wdata_i,
  output logic                 result_valid_o,
  output logic [1:0]           status_o,
  output logic                 edge_present_o,
  output logic [3:0]           row_index_o,
  output logic [15:0]          reach_row_o,
  output logic [6:0]           edge_total_o,
  output logic                 last_o
);

  gace_pkg::cnt_t     vcount_q, vcount_d;
  gace_pkg::cfg_t     cfg;
  gace_pkg::ram_req_t adj_req, clo_req;
  gace_pkg::row_t     adj_rdata, clo_rdata;

  // saturate the vertex count into its legal range
  always_comb begin
    vcount_d = vcount_q;
    if (cfg_we_i) begin
      priority if (cfg_wdata_i < gace_pkg::VcountMin) begin
        vcount_d = gace_pkg::VcountMin;
      end else if (cfg_wdata_i > gace_pkg::VcountMax) begin
        vcount_d = gace_pkg::VcountMax;
      end else begin
        vcount_d = cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= gace_pkg::VcountMax;
    end else begin
      vcount_q <= vcount_d;
    end
  end

  assign cfg.clear  = cfg_we_i;
  assign cfg.vcount = vcount_q;

  // adjacency rows
  gace_ram #(
    .WIDTH (gace_pkg::RowW),
    .DEPTH (gace_pkg::MaxVertices)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_req.we),
    .waddr_i (adj_req.waddr),
    .wdata_i (adj_req.wdata),
    .raddr_i (adj_req.raddr),
    .rdata_o (adj_rdata)
  );

  // closure rows
  gace_ram #(
    .WIDTH (gace_pkg::RowW),
    .DEPTH (gace_pkg::MaxVertices)
  ) u_clo_ram (
    .clk_i   (clk_i),
    .we_i    (clo_req.we),
    .waddr_i (clo_req.waddr),
    .wdata_i (clo_req.wdata),
    .raddr_i (clo_req.raddr),
    .rdata_o (clo_rdata)
  );

  // request sequencer
  gace_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .kind_i          (kind_i),
    .source_vertex_i (source_vertex_i),
    .dest_vertex_i   (dest_vertex_i),
    .cfg_i           (cfg),
    .adj_rdata_i     (adj_rdata),
    .clo_rdata_i     (clo_rdata),
    .adj_req_o       (adj_req),
    .clo_req_o       (clo_req),
    .busy_o          (busy_o),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .edge_present_o  (edge_present_o),
    .row_index_o     (row_index_o),
    .reach_row_o     (reach_row_o),
    .edge_total_o    (edge_total_o),
    .last_o          (last_o)
  );

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the adjacency closure engine with its own graph predictor
`timescale 1ns / 1ps
module tb;

  // cycles with no request, result or register write before the run is called hung
  localparam int unsigned StallLimit = 2000;

  typedef enum logic [1:0] {
    StepRequest,
    StepVcount,
    StepSettle
  } step_e;

  // one entry of the sender's work list
  typedef struct {
    step_e          what;
    logic [1:0]     kind;
    gace_pkg::vtx_t src;
    gace_pkg::vtx_t dst;
    logic [4:0]     vcount_val;
    int unsigned    gap;
  } step_t;

  // one result as the block should present it
  typedef struct packed {
    logic [1:0]          status;
    logic                present;
    gace_pkg::vtx_t      row;
    gace_pkg::row_t      reach;
    gace_pkg::edge_cnt_t total;
    logic                last;
  } reply_t;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       start_i         = 1'b0;
  logic [1:0] kind_i          = gace_pkg::KindAdd;
  logic [3:0] source_vertex_i = '0;
  logic [3:0] dest_vertex_i   = '0;
  logic       cfg_we_i        = 1'b0;
  logic [4:0] cfg_wdata_i     = '0;
  logic       busy_o;
  logic       result_valid_o;
  logic [1:0] status_o;
  logic       edge_present_o;
  logic [3:0] row_index_o;
  logic [15:0] reach_row_o;
  logic [6:0] edge_total_o;
  logic       last_o;

  step_t       request_q[$];
  reply_t      graph_reply_q[$];
  int unsigned gap_waited    = 0;
  int unsigned replies_due   = 0;
  int unsigned replies_seen  = 0;
  int unsigned fail_count    = 0;
  int unsigned quiet_cycles  = 0;

  // graph shadow: adjacency rows, edge count and vertex count
  gace_pkg::row_t      adj_rows[gace_pkg::MaxVertices] = '{default: '0};
  gace_pkg::edge_cnt_t edge_cnt     = '0;
  int unsigned         vertex_total = gace_pkg::MaxVertices;

  graph_adjacency_closure_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .source_vertex_i(source_vertex_i),
    .dest_vertex_i  (dest_vertex_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .edge_present_o (edge_present_o),
    .row_index_o    (row_index_o),
    .reach_row_o    (reach_row_o),
    .edge_total_o   (edge_total_o),
    .last_o         (last_o)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // vertex count write: saturate into range and drop every edge
  function automatic void load_vertex_count(logic [4:0] v);
    if (v < gace_pkg::VcountMin) begin
      vertex_total = gace_pkg::VcountMin;
    end else if (v > gace_pkg::VcountMax) begin
      vertex_total = gace_pkg::VcountMax;
    end else begin
      vertex_total = v;
    end
    foreach (adj_rows[i]) adj_rows[i] = '0;
    edge_cnt = '0;
  endfunction

  // apply one request to the shadow graph and queue the results it owes
  function automatic void compute_graph_reply(logic [1:0] k, gace_pkg::vtx_t s,
                                               gace_pkg::vtx_t d);
    gace_pkg::row_t reach[gace_pkg::MaxVertices];
    gace_pkg::row_t mask;
    reply_t         r;
    logic           in_range;
    int             i;
    int             p;
    r        = '0;
    r.last   = 1'b1;
    in_range = (s < vertex_total) && (d < vertex_total);
    if (k == gace_pkg::KindClosure) begin
      mask = (vertex_total >= gace_pkg::RowW) ? '1 :
             gace_pkg::row_t'((32'd1 << vertex_total) - 32'd1);
      for (i = 0; i < gace_pkg::MaxVertices; i++) begin
        reach[i] = (i < vertex_total) ?
                   ((adj_rows[i] | (gace_pkg::row_t'(1) << i)) & mask) : '0;
      end
      // warshall: route every row through each pivot in turn
      for (p = 0; p < vertex_total; p++) begin
        for (i = 0; i < vertex_total; i++) begin
          if (reach[i][p]) reach[i] |= reach[p];
        end
      end
      for (i = 0; i < vertex_total; i++) begin
        r.status = gace_pkg::StatOk;
        r.row    = gace_pkg::vtx_t'(i);
        r.reach  = reach[i];
        r.total  = edge_cnt;
        r.last   = (i == vertex_total - 1);
        graph_reply_q.push_back(r);
        replies_due++;
      end
      return;
    end
    case (k)
      gace_pkg::KindAdd: begin
        if (s == d) begin
          r.status = gace_pkg::StatSelfLoop;
        end else if (!in_range) begin
          r.status = gace_pkg::StatRange;
        end else begin
          if (!adj_rows[s][d]) edge_cnt = edge_cnt + 1'b1;
          adj_rows[s][d] = 1'b1;
          adj_rows[d][s] = 1'b1;
          r.status = gace_pkg::StatOk;
        end
      end
      gace_pkg::KindRemove: begin
        if (!in_range) begin
          r.status = gace_pkg::StatRange;
        end else if (!adj_rows[s][d]) begin
          r.status = gace_pkg::StatAbsent;
        end else begin
          adj_rows[s][d] = 1'b0;
          adj_rows[d][s] = 1'b0;
          edge_cnt = edge_cnt - 1'b1;
          r.status = gace_pkg::StatOk;
        end
      end
      default: begin
        if (!in_range) begin
          r.status = gace_pkg::StatRange;
        end else begin
          r.status  = gace_pkg::StatOk;
          r.present = adj_rows[s][d];
        end
      end
    endcase
    r.total = edge_cnt;
    graph_reply_q.push_back(r);
    replies_due++;
  endfunction

  function automatic void queue_request(logic [1:0] k, int unsigned s, int unsigned d,
                                        int unsigned gap);
    step_t st;
    st.what       = StepRequest;
    st.kind       = k;
    st.src        = gace_pkg::vtx_t'(s);
    st.dst        = gace_pkg::vtx_t'(d);
    st.vcount_val = '0;
    st.gap        = gap;
    request_q.push_back(st);
  endfunction

  function automatic void queue_vcount(logic [4:0] v);
    step_t st;
    st            = '{StepVcount, gace_pkg::KindAdd, '0, '0, '0, 0};
    st.vcount_val = v;
    request_q.push_back(st);
  endfunction

  function automatic void queue_settle();
    step_t st;
    st = '{StepSettle, gace_pkg::KindAdd, '0, '0, '0, 0};
    request_q.push_back(st);
  endfunction

  // mostly vertices in use, sometimes anything the field holds
  function automatic int unsigned pick_vertex(int unsigned n);
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, n - 1);
    return $urandom_range(0, 15);
  endfunction

  // sender: presents requests and vertex count writes in list order
  always @(posedge clk_i) begin : drive_proc
    step_t head;
    logic  took;
    logic  next_start;
    logic  next_we;
    if (rst_ni) begin
      took = start_i && !busy_o;
      if (took) compute_graph_reply(kind_i, source_vertex_i, dest_vertex_i);
      if (cfg_we_i) load_vertex_count(cfg_wdata_i);
      if (result_valid_o) replies_seen++;
      next_start = start_i && !took;
      next_we    = 1'b0;
      if (!next_start && request_q.size() != 0) begin
        head = request_q[0];
        if (gap_waited < head.gap) begin
          gap_waited++;
        end else if (head.what == StepRequest) begin
          void'(request_q.pop_front());
          kind_i          <= head.kind;
          source_vertex_i <= head.src;
          dest_vertex_i   <= head.dst;
          next_start = 1'b1;
          gap_waited = 0;
        end else if (replies_seen == replies_due && !busy_o && !took) begin
          // block idle with nothing owed: safe to rewrite the vertex count
          void'(request_q.pop_front());
          gap_waited = 0;
          if (head.what == StepVcount) begin
            cfg_wdata_i <= head.vcount_val;
            next_we = 1'b1;
          end
        end
      end
      start_i  <= next_start;
      cfg_we_i <= next_we;
    end
  end

  // result checker
  always @(posedge clk_i) begin : check_proc
    reply_t want;
    if (rst_ni && result_valid_o) begin
      if (graph_reply_q.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = graph_reply_q.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          fail_count++;
        end
        if (edge_present_o !== want.present) begin
          $error("edge_present: expected %0d, actual %0d", want.present, edge_present_o);
          fail_count++;
        end
        if (row_index_o !== want.row) begin
          $error("row_index: expected %0d, actual %0d", want.row, row_index_o);
          fail_count++;
        end
        if (reach_row_o !== want.reach) begin
          $error("reach_row: expected %h, actual %h", want.reach, reach_row_o);
          fail_count++;
        end
        if (edge_total_o !== want.total) begin
          $error("edge_total: expected %0d, actual %0d", want.total, edge_total_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  // hang detection
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // stimulus list, reset and end of run
  initial begin : run_proc
    int unsigned phase;
    int unsigned idx;
    int unsigned nv;
    int unsigned n_eff;
    int unsigned add_pct;
    int unsigned pick;
    int unsigned s;
    int unsigned d;
    int unsigned j;
    int unsigned gap;
    logic        calm;
    logic [1:0]  k;
    int unsigned pair_s[$];
    int unsigned pair_d[$];

    // edge cases at the reset vertex count of 16
    queue_request(gace_pkg::KindAdd, 0, 15, 0);
    queue_request(gace_pkg::KindAdd, 15, 0, 0);
    queue_request(gace_pkg::KindAdd, 5, 5, 0);
    queue_request(gace_pkg::KindQuery, 0, 15, 0);
    queue_request(gace_pkg::KindQuery, 15, 0, 2);
    queue_request(gace_pkg::KindQuery, 3, 3, 0);
    queue_request(gace_pkg::KindRemove, 3, 3, 0);
    queue_request(gace_pkg::KindRemove, 15, 0, 0);
    queue_request(gace_pkg::KindRemove, 0, 15, 0);
    queue_request(gace_pkg::KindAdd, 1, 2, 0);
    queue_request(gace_pkg::KindAdd, 2, 7, 0);
    queue_request(gace_pkg::KindClosure, 15, 15, 0);
    // small graph: out of range endpoints, self loop checked first
    queue_vcount(5'd4);
    queue_request(gace_pkg::KindAdd, 3, 9, 0);
    queue_request(gace_pkg::KindAdd, 9, 9, 0);
    queue_request(gace_pkg::KindRemove, 12, 1, 0);
    queue_request(gace_pkg::KindQuery, 0, 10, 0);
    queue_request(gace_pkg::KindAdd, 0, 1, 0);
    queue_request(gace_pkg::KindAdd, 3, 2, 0);
    queue_request(gace_pkg::KindClosure, 0, 0, 0);
    // count of zero saturates to one vertex, oversize counts to sixteen
    queue_vcount(5'd0);
    queue_request(gace_pkg::KindQuery, 0, 0, 0);
    queue_request(gace_pkg::KindClosure, 0, 0, 0);
    queue_vcount(5'd31);
    queue_request(gace_pkg::KindClosure, 0, 0, 0);
    queue_vcount(5'd17);
    queue_request(gace_pkg::KindAdd, 14, 15, 0);

    // random phases, each at its own vertex count
    for (phase = 0; phase < 8; phase++) begin
      if (phase == 0 || phase == 7) begin
        nv = 16;
      end else if (phase == 1) begin
        nv = $urandom_range(1, 3);
      end else begin
        nv = $urandom_range(0, 31);
      end
      queue_vcount(nv[4:0]);
      n_eff   = (nv == 0) ? 1 : ((nv > 16) ? 16 : nv);
      add_pct = $urandom_range(30, 60);
      calm    = (phase == 7) || ($urandom_range(0, 2) == 0);
      pair_s.delete();
      pair_d.delete();
      for (idx = 0; idx < 60; idx++) begin
        // hold the sender until the block has answered everything
        if (idx == 30 && (phase == 0 || $urandom_range(0, 1) == 1)) queue_settle();
        pick = $urandom_range(0, 99);
        s    = pick_vertex(n_eff);
        d    = pick_vertex(n_eff);
        gap  = (calm || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 19);
        if (pick < add_pct) begin
          k = gace_pkg::KindAdd;
          pair_s.push_back(s);
          pair_d.push_back(d);
        end else begin
          if (pick < add_pct + 20) begin
            k = gace_pkg::KindRemove;
          end else if (pick < 90) begin
            k = gace_pkg::KindQuery;
          end else begin
            k = gace_pkg::KindClosure;
          end
          // often aim removes and queries at edges added earlier, reversed
          if (k != gace_pkg::KindClosure && pair_s.size() != 0 &&
              $urandom_range(0, 2) != 0) begin
            j = $urandom_range(0, pair_s.size() - 1);
            s = pair_d[j];
            d = pair_s[j];
          end
        end
        queue_request(k, s, d, gap);
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || start_i) @(posedge clk_i);
    while (graph_reply_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/gace_pkg.sv
design/gace_ram.sv
design/gace_seq.sv
design/graph_adjacency_closure_engine.sv
tb/tb.sv
